/* rtl/core/pll_pkg.sv */
// Shared types and codes for the pattern language lexer.
// Transaction payload structs, result and token codes, character class bundle.
// No dependencies.
`timescale 1ns / 1ps

package pll_pkg;

  localparam int MAX_RESULTS = 3;

  // result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_EOL   = 2'd2;

  // error codes
  localparam logic EC_UNKNOWN    = 1'b0;
  localparam logic EC_OPEN_REGEX = 1'b1;

  // token types
  localparam logic [4:0] TT_RGX    = 5'd0;
  localparam logic [4:0] TT_NUM    = 5'd1;
  localparam logic [4:0] TT_IDENT  = 5'd2;
  localparam logic [4:0] TT_DOT    = 5'd3;
  localparam logic [4:0] TT_SEP    = 5'd4;
  localparam logic [4:0] TT_DOLLAR = 5'd5;
  localparam logic [4:0] TT_HASH   = 5'd6;
  localparam logic [4:0] TT_PIPE   = 5'd7;
  localparam logic [4:0] TT_LBRACE = 5'd8;
  localparam logic [4:0] TT_RBRACE = 5'd9;
  localparam logic [4:0] TT_LBRACK = 5'd10;
  localparam logic [4:0] TT_RBRACK = 5'd11;
  localparam logic [4:0] TT_LPAREN = 5'd12;
  localparam logic [4:0] TT_RPAREN = 5'd13;
  localparam logic [4:0] TT_EQ     = 5'd14;
  localparam logic [4:0] TT_TLD    = 5'd15;
  localparam logic [4:0] TT_LT     = 5'd16;
  localparam logic [4:0] TT_GT     = 5'd17;
  localparam logic [4:0] TT_EQEQ   = 5'd18;
  localparam logic [4:0] TT_ARROW  = 5'd19;
  localparam logic [4:0] TT_SHL    = 5'd20;
  localparam logic [4:0] TT_SHR    = 5'd21;
  localparam logic [4:0] TT_NE     = 5'd22;

  typedef struct packed {
    logic [7:0]  char_byte;
    logic [15:0] line_number;
    logic        end_of_line;
  } pll_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  token_type;
    logic [15:0] token_line;
    logic [11:0] start_column;
    logic [12:0] token_length;
    logic [31:0] number_value;
    logic        number_saturated;
    logic        error_code;
    logic        last_result;
  } pll_out_t;

  typedef struct packed {
    logic       blank;
    logic       punct;
    logic [4:0] punct_type;
    logic       digit;
    logic [3:0] digit_val;
    logic       ident;
    logic       control;
    logic       quote;
    logic       backslash;
    logic       eq;
    logic       tilde;
    logic       lt;
    logic       gt;
    logic       bang;
  } pll_class_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } pll_load_t;

endpackage

/* rtl/core/pll_char_class.sv */
// Character classifier: decodes one byte into lexer character classes.
// Depends on pll_pkg.
`timescale 1ns / 1ps

module pll_char_class (
  input  logic [7:0]          char_byte,
  output pll_pkg::pll_class_t cls
);
  import pll_pkg::*;

  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_PIPE   = "|";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_TILDE  = "~";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  always_comb begin
    cls            = '0;
    cls.blank      = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
    cls.digit      = (char_byte >= "0") && (char_byte <= "9");
    cls.digit_val  = char_byte[3:0];
    cls.ident      = cls.digit || ((char_byte >= "A") && (char_byte <= "Z")) ||
                     ((char_byte >= "a") && (char_byte <= "z")) ||
                     (char_byte == "-") || (char_byte == "_");
    cls.control    = (char_byte < 8'd32) || (char_byte == CH_DEL);
    cls.quote      = (char_byte == CH_QUOTE);
    cls.backslash  = (char_byte == CH_BSLASH);
    cls.eq         = (char_byte == CH_EQ);
    cls.tilde      = (char_byte == CH_TILDE);
    cls.lt         = (char_byte == CH_LT);
    cls.gt         = (char_byte == CH_GT);
    cls.bang       = (char_byte == CH_BANG);
    cls.punct      = 1'b1;
    case (char_byte)
      CH_DOT:    cls.punct_type = TT_DOT;
      CH_COMMA:  cls.punct_type = TT_SEP;
      CH_DOLLAR: cls.punct_type = TT_DOLLAR;
      CH_HASH:   cls.punct_type = TT_HASH;
      CH_PIPE:   cls.punct_type = TT_PIPE;
      CH_LBRACE: cls.punct_type = TT_LBRACE;
      CH_RBRACE: cls.punct_type = TT_RBRACE;
      CH_LBRACK: cls.punct_type = TT_LBRACK;
      CH_RBRACK: cls.punct_type = TT_RBRACK;
      CH_LPAREN: cls.punct_type = TT_LPAREN;
      CH_RPAREN: cls.punct_type = TT_RPAREN;
      default: begin
        cls.punct      = 1'b0;
        cls.punct_type = TT_RGX;
      end
    endcase
  end

endmodule

/* rtl/core/pll_lexer_core.sv */
// Lexer state machine: consumes one classified byte per transaction and
// forms up to three results, including end-of-line flush. Depends on pll_pkg.
`timescale 1ns / 1ps

module pll_lexer_core #(
  parameter int MAX_LINE_LENGTH = 4096,
  parameter int NUMBER_WIDTH    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pll_pkg::pll_in_t    in_data,
  input  pll_pkg::pll_class_t cls,
  output pll_pkg::pll_out_t   res_o [pll_pkg::MAX_RESULTS],
  output logic [1:0]          res_count
);
  import pll_pkg::*;

  localparam int CW = $clog2(MAX_LINE_LENGTH + 1);
  localparam int NW = NUMBER_WIDTH;

  typedef enum logic [3:0] {
    ST_INIT, ST_NUM, ST_IDENT, ST_REGEX, ST_REGEX_ESC, ST_EQ, ST_TILDE,
    ST_LT, ST_GT, ST_BANG, ST_ERROR
  } lex_state_t;

  lex_state_t        st_r, st_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     tok_r, tok_nxt;
  logic [CW-1:0]     plen_r, plen_nxt;
  logic [NW-1:0]     acc_r, acc_nxt;
  logic              sat_r, sat_nxt;

  logic [CW-1:0]     col_end;
  logic [NW+3:0]     prod;
  logic              do_init;
  logic [1:0]        n_v;
  logic              op_hit;
  logic [4:0]        op_pair, op_single;
  pll_out_t          res_v [MAX_RESULTS];

  function automatic logic [CW-1:0] clip_len(input logic [CW:0] x);
    clip_len = (x > (CW+1)'(MAX_LINE_LENGTH)) ? CW'(MAX_LINE_LENGTH) : x[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] clip_col(input logic [CW-1:0] x);
    clip_col = (x > CW'(MAX_LINE_LENGTH - 1)) ? CW'(MAX_LINE_LENGTH - 1) : x;
  endfunction

  function automatic pll_out_t make_res(input logic [1:0]    kind,
                                        input logic [4:0]    ttype,
                                        input logic [15:0]   line,
                                        input logic [CW-1:0] start,
                                        input logic [CW-1:0] len,
                                        input logic [NW-1:0] value,
                                        input logic          vsat,
                                        input logic          err);
    pll_out_t r;
    r.result_kind      = kind;
    r.token_type       = ttype;
    r.token_line       = line;
    r.start_column     = 12'(clip_col(start));
    r.token_length     = 13'(len);
    r.number_value     = 32'(value);
    r.number_saturated = vsat;
    r.error_code       = err;
    r.last_result      = 1'b0;
    return r;
  endfunction

  // times ten plus digit; overflow shows in the top four bits
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                {NW'(0), cls.digit_val};

  assign col_end = clip_len({1'b0, col_r} + (CW+1)'(1));

  always_comb begin
    op_hit    = 1'b0;
    op_pair   = TT_EQEQ;
    op_single = TT_EQ;
    case (st_r)
      ST_EQ: begin
        op_hit = cls.eq;
      end
      ST_TILDE: begin
        op_hit    = cls.gt;
        op_pair   = TT_ARROW;
        op_single = TT_TLD;
      end
      ST_LT: begin
        op_hit    = cls.lt;
        op_pair   = TT_SHL;
        op_single = TT_LT;
      end
      ST_GT: begin
        op_hit    = cls.gt;
        op_pair   = TT_SHR;
        op_single = TT_GT;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    tok_nxt  = tok_r;
    plen_nxt = plen_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    col_nxt  = col_end;
    do_init  = 1'b0;
    n_v      = 2'd0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res_v[k] = '0;
    end

    case (st_r)
      ST_INIT: do_init = 1'b1;
      ST_NUM: begin
        if (cls.digit) begin
          plen_nxt = clip_len({1'b0, plen_r} + (CW+1)'(1));
          if (prod[NW+3:NW] != 4'd0) begin
            acc_nxt = '1;
            sat_nxt = 1'b1;
          end else begin
            acc_nxt = prod[NW-1:0];
          end
        end else begin
          res_v[n_v] = make_res(RK_TOKEN, TT_NUM, in_data.line_number, tok_r,
                                plen_r, acc_r, sat_r, EC_UNKNOWN);
          n_v     = n_v + 2'd1;
          acc_nxt = '0;
          sat_nxt = 1'b0;
          st_nxt  = ST_INIT;
          do_init = 1'b1;
        end
      end
      ST_IDENT: begin
        if (cls.ident) begin
          plen_nxt = clip_len({1'b0, plen_r} + (CW+1)'(1));
        end else begin
          res_v[n_v] = make_res(RK_TOKEN, TT_IDENT, in_data.line_number, tok_r,
                                plen_r, '0, 1'b0, EC_UNKNOWN);
          n_v     = n_v + 2'd1;
          st_nxt  = ST_INIT;
          do_init = 1'b1;
        end
      end
      ST_REGEX, ST_REGEX_ESC: begin
        if (cls.control) begin
          res_v[n_v] = make_res(RK_ERROR, TT_RGX, in_data.line_number, col_r,
                                '0, '0, 1'b0, EC_UNKNOWN);
          n_v    = n_v + 2'd1;
          st_nxt = ST_ERROR;
        end else if (cls.quote && (st_r == ST_REGEX)) begin
          res_v[n_v] = make_res(RK_TOKEN, TT_RGX, in_data.line_number, tok_r,
                                clip_len({1'b0, plen_r} + (CW+1)'(1)), '0, 1'b0,
                                EC_UNKNOWN);
          n_v    = n_v + 2'd1;
          st_nxt = ST_INIT;
        end else begin
          plen_nxt = clip_len({1'b0, plen_r} + (CW+1)'(1));
          st_nxt   = (cls.backslash && (st_r == ST_REGEX)) ? ST_REGEX_ESC : ST_REGEX;
        end
      end
      ST_EQ, ST_TILDE, ST_LT, ST_GT: begin
        st_nxt = ST_INIT;
        if (op_hit) begin
          res_v[n_v] = make_res(RK_TOKEN, op_pair, in_data.line_number, tok_r,
                                CW'(2), '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end else begin
          res_v[n_v] = make_res(RK_TOKEN, op_single, in_data.line_number, tok_r,
                                CW'(1), '0, 1'b0, EC_UNKNOWN);
          n_v     = n_v + 2'd1;
          do_init = 1'b1;
        end
      end
      ST_BANG: begin
        if (cls.eq) begin
          res_v[n_v] = make_res(RK_TOKEN, TT_NE, in_data.line_number, tok_r,
                                CW'(2), '0, 1'b0, EC_UNKNOWN);
          n_v    = n_v + 2'd1;
          st_nxt = ST_INIT;
        end else begin
          res_v[n_v] = make_res(RK_ERROR, TT_RGX, in_data.line_number, col_r,
                                '0, '0, 1'b0, EC_UNKNOWN);
          n_v    = n_v + 2'd1;
          st_nxt = ST_ERROR;
        end
      end
      default: ;
    endcase

    // start of a new token, from the idle state or on the byte that ended one
    if (do_init) begin
      if (cls.blank) begin
        st_nxt = ST_INIT;
      end else if (cls.punct) begin
        res_v[n_v] = make_res(RK_TOKEN, cls.punct_type, in_data.line_number, col_r,
                              CW'(1), '0, 1'b0, EC_UNKNOWN);
        n_v = n_v + 2'd1;
      end else if (cls.eq || cls.tilde || cls.lt || cls.gt || cls.bang ||
                   cls.quote || cls.ident) begin
        tok_nxt  = col_r;
        plen_nxt = CW'(1);
        if (cls.eq) begin
          st_nxt = ST_EQ;
        end else if (cls.tilde) begin
          st_nxt = ST_TILDE;
        end else if (cls.lt) begin
          st_nxt = ST_LT;
        end else if (cls.gt) begin
          st_nxt = ST_GT;
        end else if (cls.bang) begin
          st_nxt = ST_BANG;
        end else if (cls.quote) begin
          st_nxt = ST_REGEX;
        end else if (cls.digit) begin
          st_nxt  = ST_NUM;
          acc_nxt = NW'(cls.digit_val);
          sat_nxt = 1'b0;
        end else begin
          st_nxt = ST_IDENT;
        end
      end else begin
        res_v[n_v] = make_res(RK_ERROR, TT_RGX, in_data.line_number, col_r,
                              '0, '0, 1'b0, EC_UNKNOWN);
        n_v    = n_v + 2'd1;
        st_nxt = ST_ERROR;
      end
    end

    // end of line: flush whatever is pending, then the marker
    if (in_data.end_of_line) begin
      case (st_nxt)
        ST_NUM: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_NUM, in_data.line_number, tok_nxt,
                                plen_nxt, acc_nxt, sat_nxt, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_IDENT: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_IDENT, in_data.line_number, tok_nxt,
                                plen_nxt, '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_REGEX, ST_REGEX_ESC: begin
          res_v[n_v] = make_res(RK_ERROR, TT_RGX, in_data.line_number, col_end,
                                '0, '0, 1'b0, EC_OPEN_REGEX);
          n_v = n_v + 2'd1;
        end
        ST_EQ: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_EQ, in_data.line_number, tok_nxt,
                                CW'(1), '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_TILDE: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_TLD, in_data.line_number, tok_nxt,
                                CW'(1), '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_LT: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_LT, in_data.line_number, tok_nxt,
                                CW'(1), '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_GT: begin
          res_v[n_v] = make_res(RK_TOKEN, TT_GT, in_data.line_number, tok_nxt,
                                CW'(1), '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        ST_BANG: begin
          res_v[n_v] = make_res(RK_ERROR, TT_RGX, in_data.line_number, col_end,
                                '0, '0, 1'b0, EC_UNKNOWN);
          n_v = n_v + 2'd1;
        end
        default: ;
      endcase
      res_v[n_v] = make_res(RK_EOL, TT_RGX, in_data.line_number, '0, col_end,
                            '0, 1'b0, EC_UNKNOWN);
      n_v = n_v + 2'd1;
      st_nxt   = ST_INIT;
      col_nxt  = '0;
      tok_nxt  = '0;
      plen_nxt = '0;
      acc_nxt  = '0;
      sat_nxt  = 1'b0;
    end

    if (n_v != 2'd0) begin
      res_v[n_v - 2'd1].last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_INIT;
      col_r  <= '0;
      tok_r  <= '0;
      plen_r <= '0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
    end else if (accept) begin
      st_r   <= st_nxt;
      col_r  <= col_nxt;
      tok_r  <= tok_nxt;
      plen_r <= plen_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign res_o     = res_v;
  assign res_count = n_v;

endmodule

/* rtl/core/pll_result_queue.sv */
// Three-slot result buffer: loads all results of one byte at once and
// hands them out one transaction per cycle while out_ready is high. Depends on pll_pkg.
`timescale 1ns / 1ps

module pll_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  pll_pkg::pll_load_t  load,
  input  pll_pkg::pll_out_t   load_data [pll_pkg::MAX_RESULTS],
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output pll_pkg::pll_out_t   out_data
);
  import pll_pkg::*;

  pll_out_t   q_r [MAX_RESULTS];
  pll_out_t   q_nxt [MAX_RESULTS];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;
  // room for a fresh set once the last held result leaves
  assign space     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load.valid) begin
      q_nxt   = load_data;
      cnt_nxt = load.count;
    end else if (pop) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        q_nxt[k] = q_r[k + 1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))
    else $error("result set loaded over undelivered results");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid && (load.count != 2'd0) |=> out_valid)
    else $error("loaded results not presented");

  a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && q_r[0].last_result |-> (cnt_r == 2'd1))
    else $error("last-result flag before the final result");

  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> q_r[0].last_result)
    else $error("final result of a byte lacks last-result flag");
`endif

endmodule

/* rtl/core/pattern_language_lexer.sv */
// Output: a byte's first result is offered in the cycle after its transaction.
// Throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; a byte yielding more holds the input until the last of its
// results leaves the three-slot buffer, which drains one per cycle under out_ready.
// Reset: synchronous, active low; clears lexer state, column and buffer count.
`timescale 1ns / 1ps

module pattern_language_lexer #(
  parameter int MAX_LINE_LENGTH = 4096,
  parameter int NUMBER_WIDTH    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pll_pkg::pll_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pll_pkg::pll_out_t  out_data
);
  import pll_pkg::*;

  pll_class_t cls;
  pll_out_t   res [MAX_RESULTS];
  logic [1:0] res_count;
  pll_load_t  load;
  logic       accept;

  assign accept     = in_valid && in_ready;
  assign load.valid = accept;
  assign load.count = res_count;

  pll_char_class u_class (
    .char_byte (in_data.char_byte),
    .cls       (cls)
  );

  pll_lexer_core #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .NUMBER_WIDTH    (NUMBER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cls       (cls),
    .res_o     (res),
    .res_count (res_count)
  );

  pll_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
